@@ hw/rtl/sqmsd_pkg.sv @@
// ----------------------------------------------------------------------------
// sqmsd_pkg
// Shared types and default constants for the shared queue dispatcher.
// ----------------------------------------------------------------------------
package sqmsd_pkg;

  localparam int QUEUE_DEPTH_DEF  = 8;
  localparam int SERVER_COUNT_DEF = 2;
  localparam int SERVICE_BITS_DEF = 16;
  localparam int IN_SVC_W         = 16;
  localparam int LEVEL_W          = 4;
  localparam int BUSY_W           = 2;
  localparam int TOTAL_W          = 32;

  typedef struct packed {
    logic                arrival_now;
    logic [IN_SVC_W-1:0] service_time;
  } in_word_t;

  typedef struct packed {
    logic               dropped;
    logic [TOTAL_W-1:0] drop_total;
    logic [LEVEL_W-1:0] queue_level;
    logic [BUSY_W-1:0]  servers_busy;
  } out_word_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_APPEND,
    S_FETCH0,
    S_TAKE0,
    S_RETIRE,
    S_FETCH1,
    S_TAKE1,
    S_COUNT
  } state_t;

  typedef struct packed {
    logic latch;
    logic append;
    logic take;
    logic extra;
    logic retire;
    logic countdown;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic idx_last;
  } sts_t;

endpackage

@@ hw/rtl/sqmsd_datapath.sv @@
// ----------------------------------------------------------------------------
// sqmsd_datapath
// Pending job ring buffer, server countdown registers, drop counter and
// the result register, all driven by controller commands.
// ----------------------------------------------------------------------------
module sqmsd_datapath
  import sqmsd_pkg::*;
#(
  parameter int QUEUE_DEPTH  = QUEUE_DEPTH_DEF,
  parameter int SERVER_COUNT = SERVER_COUNT_DEF,
  parameter int SERVICE_BITS = SERVICE_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  in_word_t  in_word,
  input  cmd_t      cmd,
  output sts_t      sts,
  output out_word_t out_word
);

  localparam int AW  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW  = $clog2(QUEUE_DEPTH + 1);
  localparam int SIW = (SERVER_COUNT > 1) ? $clog2(SERVER_COUNT) : 1;
  localparam int SW  = (SERVICE_BITS > IN_SVC_W) ? SERVICE_BITS : IN_SVC_W;

  logic [SERVICE_BITS-1:0] mem [QUEUE_DEPTH];
  logic [SERVICE_BITS-1:0] rd_data_r;

  logic [AW-1:0]             head_r;
  logic [CW-1:0]             cnt_r;
  logic [SERVER_COUNT-1:0]   active_r;
  logic [SERVICE_BITS-1:0]   ticks_r [SERVER_COUNT];
  logic [SIW-1:0]            idx_r;
  logic [TOTAL_W-1:0]        drop_total_r;
  logic                      drop_r;
  logic                      arrival_r;
  logic [SERVICE_BITS-1:0]   svc_r;
  out_word_t                 out_r;

  logic [SW-1:0]           svc_ext;
  logic [SW-1:0]           svc_max;
  logic [SW-1:0]           svc_sat;
  logic [SERVICE_BITS-1:0] svc_cl;
  logic [AW:0]             tail_sum;
  logic [AW-1:0]           tail;
  logic                    full;
  logic                    take_ok;

  always_comb begin
    svc_ext = SW'(in_word.service_time);
    svc_max = SW'({SERVICE_BITS{1'b1}});
    svc_sat = (svc_ext > svc_max) ? svc_max : svc_ext;
    svc_cl  = SERVICE_BITS'(svc_sat);
    if (svc_cl == '0) begin
      svc_cl = SERVICE_BITS'(1);
    end
  end

  always_comb begin
    tail_sum = {1'b0, head_r} + (AW+1)'(cnt_r);
    if (tail_sum >= (AW+1)'(QUEUE_DEPTH)) begin
      tail_sum = tail_sum - (AW+1)'(QUEUE_DEPTH);
    end
    tail    = tail_sum[AW-1:0];
    full    = (cnt_r >= CW'(QUEUE_DEPTH));
    take_ok = !active_r[idx_r] && (cnt_r != '0);
  end

  assign sts.idx_last = (idx_r == SIW'(SERVER_COUNT - 1));

  always_ff @(posedge clk) begin
    if (cmd.append && arrival_r && !full) begin
      mem[tail] <= svc_r;
    end
    rd_data_r <= mem[head_r];
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      svc_r <= svc_cl;
    end
    if (cmd.load_out) begin
      out_r.dropped      <= drop_r;
      out_r.drop_total   <= drop_total_r;
      out_r.queue_level  <= LEVEL_W'(cnt_r);
      out_r.servers_busy <= BUSY_W'(active_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r       <= '0;
      cnt_r        <= '0;
      active_r     <= '0;
      idx_r        <= '0;
      drop_total_r <= '0;
      drop_r       <= 1'b0;
      arrival_r    <= 1'b0;
      for (int i = 0; i < SERVER_COUNT; i++) begin
        ticks_r[i] <= '0;
      end
    end else begin
      if (cmd.latch) begin
        arrival_r <= in_word.arrival_now;
      end
      if (cmd.append) begin
        drop_r <= arrival_r && full;
        if (arrival_r && full) begin
          if (drop_total_r != '1) begin
            drop_total_r <= drop_total_r + TOTAL_W'(1);
          end
        end else if (arrival_r) begin
          cnt_r <= cnt_r + CW'(1);
        end
      end
      if (cmd.take) begin
        idx_r <= sts.idx_last ? '0 : idx_r + SIW'(1);
        if (take_ok) begin
          ticks_r[idx_r]  <= cmd.extra ? rd_data_r : rd_data_r - SERVICE_BITS'(1);
          active_r[idx_r] <= 1'b1;
          cnt_r           <= cnt_r - CW'(1);
          head_r          <= (head_r == AW'(QUEUE_DEPTH - 1)) ? '0 : head_r + AW'(1);
        end
      end
      if (cmd.retire) begin
        for (int i = 0; i < SERVER_COUNT; i++) begin
          if (active_r[i] && ticks_r[i] == '0) begin
            active_r[i] <= 1'b0;
          end
        end
      end
      if (cmd.countdown) begin
        for (int i = 0; i < SERVER_COUNT; i++) begin
          if (active_r[i] && ticks_r[i] != '0) begin
            ticks_r[i] <= ticks_r[i] - SERVICE_BITS'(1);
          end
        end
      end
    end
  end

  assign out_word = out_r;

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(QUEUE_DEPTH))
    else $error("pending count exceeds queue depth");
  a_head_bound: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, head_r} < (AW+1)'(QUEUE_DEPTH))
    else $error("head pointer out of range");
  a_drop_mono: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n |=> drop_total_r >= $past(drop_total_r))
    else $error("drop counter decreased");
`endif

endmodule

@@ hw/rtl/sqmsd_ctrl.sv @@
// ----------------------------------------------------------------------------
// sqmsd_ctrl
// Tick sequencer: append, a dispatch pass over the servers, retire, a second
// dispatch pass, countdown and hand-off to the result register.
// ----------------------------------------------------------------------------
module sqmsd_ctrl
  import sqmsd_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  output logic out_valid,
  input  logic out_stall,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state_r;
  state_t state_nxt;
  logic   out_valid_r;
  logic   out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    out_valid_nxt = out_valid_r && out_stall;
    case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.latch = 1'b1;
          state_nxt = S_APPEND;
        end
      end
      S_APPEND: begin
        cmd.append = 1'b1;
        state_nxt  = S_FETCH0;
      end
      S_FETCH0: begin
        state_nxt = S_TAKE0;
      end
      S_TAKE0: begin
        cmd.take  = 1'b1;
        state_nxt = sts.idx_last ? S_RETIRE : S_FETCH0;
      end
      S_RETIRE: begin
        cmd.retire = 1'b1;
        state_nxt  = S_FETCH1;
      end
      S_FETCH1: begin
        state_nxt = S_TAKE1;
      end
      S_TAKE1: begin
        cmd.take  = 1'b1;
        cmd.extra = 1'b1;
        state_nxt = sts.idx_last ? S_COUNT : S_FETCH1;
      end
      S_COUNT: begin
        if (!out_valid_r || !out_stall) begin
          cmd.load_out  = 1'b1;
          cmd.countdown = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;

`ifndef SYNTHESIS
  a_idle_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && !in_valid) |=> state_r == S_IDLE)
    else $error("sequencer left idle without an input word");
  a_out_rise: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_COUNT))
    else $error("result raised outside the countdown step");
  a_pass_loop: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_TAKE0 && !sts.idx_last) |=> state_r == S_FETCH0)
    else $error("first dispatch pass skipped a server");
`endif

endmodule

@@ hw/rtl/shared_queue_multi_server_dispatch.sv @@
// ----------------------------------------------------------------------------
// shared_queue_multi_server_dispatch
// One input word per tick; the sequencer visits each server once per dispatch
// pass through the queue RAM read port, and no new word is taken until the
// tick is done. out_valid rises when the countdown step loads the result;
// one result is held while the next tick is being worked.
// Synchronous reset empties the queue, idles all servers and clears the count.
// ----------------------------------------------------------------------------
module shared_queue_multi_server_dispatch
  import sqmsd_pkg::*;
#(
  parameter int QUEUE_DEPTH  = QUEUE_DEPTH_DEF,
  parameter int SERVER_COUNT = SERVER_COUNT_DEF,
  parameter int SERVICE_BITS = SERVICE_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_word_t  in_word,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_word
);

  cmd_t cmd;
  sts_t sts;

  sqmsd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  sqmsd_datapath #(
    .QUEUE_DEPTH  (QUEUE_DEPTH),
    .SERVER_COUNT (SERVER_COUNT),
    .SERVICE_BITS (SERVICE_BITS)
  ) u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_word  (in_word),
    .cmd      (cmd),
    .sts      (sts),
    .out_word (out_word)
  );

endmodule

@@ sim/dispatch_checker.sv @@
// ----------------------------------------------------------------------------
// dispatch_checker
// Watches both channels of the shared queue dispatcher. Every accepted input
// word advances a private copy of the queue, the servers and the drop count
// by one tick. The expected status word is queued, and every accepted output
// word is compared with the oldest expected status, field by field.
// ----------------------------------------------------------------------------
module dispatch_checker
  import sqmsd_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_stall,
  input  in_word_t  in_word,
  input  logic      out_valid,
  input  logic      out_stall,
  input  out_word_t out_word,
  output int        fail_count,
  output int        waiting
);

  logic [IN_SVC_W-1:0] queued_svc [QUEUE_DEPTH_DEF];
  int unsigned         queued_jobs;
  logic                srv_busy [SERVER_COUNT_DEF];
  logic [IN_SVC_W-1:0] srv_left [SERVER_COUNT_DEF];
  logic [TOTAL_W-1:0]  drop_cnt;
  out_word_t           expected_status [$];

  initial begin
    fail_count = 0;
    waiting    = 0;
  end

  function automatic void clear_state();
    queued_jobs = 0;
    drop_cnt    = '0;
    for (int i = 0; i < QUEUE_DEPTH_DEF; i++) begin
      queued_svc[i] = '0;
    end
    for (int i = 0; i < SERVER_COUNT_DEF; i++) begin
      srv_busy[i] = 1'b0;
      srv_left[i] = '0;
    end
  endfunction

  // Idle servers pull jobs from the head in server order. A job handed out
  // before retirement finishes one tick earlier than one handed out after.
  function automatic void hand_out_jobs(input logic late);
    for (int i = 0; i < SERVER_COUNT_DEF; i++) begin
      if (!srv_busy[i] && queued_jobs > 0) begin
        srv_left[i] = queued_svc[0] - 16'd1 + late;
        srv_busy[i] = 1'b1;
        for (int k = 0; k + 1 < QUEUE_DEPTH_DEF; k++) begin
          queued_svc[k] = queued_svc[k + 1];
        end
        queued_svc[QUEUE_DEPTH_DEF - 1] = '0;
        queued_jobs--;
      end
    end
  endfunction

  function automatic out_word_t advance_tick(input in_word_t w);
    logic [IN_SVC_W-1:0] svc;
    out_word_t           r;
    svc = (w.service_time == '0) ? IN_SVC_W'(1) : w.service_time;
    r   = '0;
    if (w.arrival_now) begin
      if (queued_jobs >= QUEUE_DEPTH_DEF) begin
        r.dropped = 1'b1;
        if (drop_cnt != '1) begin
          drop_cnt++;
        end
      end else begin
        queued_svc[queued_jobs] = svc;
        queued_jobs++;
      end
    end
    hand_out_jobs(1'b0);
    for (int i = 0; i < SERVER_COUNT_DEF; i++) begin
      if (srv_busy[i] && srv_left[i] == '0) begin
        srv_busy[i] = 1'b0;
      end
    end
    hand_out_jobs(1'b1);
    for (int i = 0; i < SERVER_COUNT_DEF; i++) begin
      if (srv_busy[i]) begin
        if (srv_left[i] != '0) begin
          srv_left[i]--;
        end
        r.servers_busy[i] = 1'b1;
      end
    end
    r.drop_total  = drop_cnt;
    r.queue_level = LEVEL_W'(queued_jobs);
    return r;
  endfunction

  task automatic compare_field(input string name, input longint unsigned exp_v,
                               input longint unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    out_word_t exp_w;
    if (!rst_n) begin
      clear_state();
      expected_status.delete();
    end else begin
      if (in_valid && !in_stall) begin
        expected_status.push_back(advance_tick(in_word));
      end
      if (out_valid && !out_stall) begin
        if (expected_status.size() == 0) begin
          $error("Output word arrived with no status expected.");
          fail_count++;
        end else begin
          exp_w = expected_status.pop_front();
          compare_field("dropped", 64'(exp_w.dropped), 64'(out_word.dropped));
          compare_field("drop_total", 64'(exp_w.drop_total),
                        64'(out_word.drop_total));
          compare_field("queue_level", 64'(exp_w.queue_level),
                        64'(out_word.queue_level));
          compare_field("servers_busy", 64'(exp_w.servers_busy),
                        64'(out_word.servers_busy));
        end
      end
    end
    waiting = expected_status.size();
  end

endmodule

@@ sim/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Drives ticks into the shared queue dispatcher: a directed opening that
// fills the queue behind two long jobs and drops arrivals with extreme
// service times, then bursts of random load, then two very long jobs. Both
// sides idle at random, and the receiver holds off once for a long stretch.
// ----------------------------------------------------------------------------
module tb_top;
  import sqmsd_pkg::*;

  localparam int CYCLE_LIMIT = 400000;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_word_t  in_word;
  logic      out_valid;
  logic      out_stall;
  out_word_t out_word;
  int        fail_count;
  int        waiting;
  int        cycle_count = 0;
  bit        quiet_burst = 1'b0;

  shared_queue_multi_server_dispatch u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

  dispatch_checker u_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_word    (in_word),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_word   (out_word),
    .fail_count (fail_count),
    .waiting    (waiting)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 65) begin
      return 0;
    end else if (r < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(10, 40);
  endfunction

  task automatic offer(input logic arrive, input logic [IN_SVC_W-1:0] svc);
    in_word_t w;
    int       gap;
    bit       ready;
    w.arrival_now  = arrive;
    w.service_time = svc;
    gap = quiet_burst ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    do begin
      @(negedge clk);
      ready = !in_stall;
      @(posedge clk);
    end while (!ready);
  endtask

  // The receiver runs on its own; on its fortieth round it holds off long
  // enough for the block to fill and stall its input.
  initial begin
    int run;
    int gap;
    int rounds;
    rounds = 0;
    forever begin
      run = $urandom_range(1, 20);
      gap = (rounds == 39) ? 400 : pick_gap();
      out_stall <= 1'b0;
      repeat (run) @(posedge clk);
      if (gap > 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(posedge clk);
      end
      rounds++;
    end
  end

  initial begin
    int                  sent;
    int                  burst_len;
    int                  arr_pct;
    int                  svc_max;
    logic                arrive;
    logic [IN_SVC_W-1:0] svc;
    in_valid <= 1'b0;
    in_word  <= '0;
    rst_n    <= 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Two long jobs occupy both servers while the queue fills and overflows.
    offer(1'b1, 16'd20);
    offer(1'b1, 16'd20);
    repeat (10) offer(1'b1, 16'd3);
    offer(1'b1, 16'hFFFF);
    offer(1'b1, 16'h0000);
    offer(1'b1, 16'hAAAA);
    offer(1'b1, 16'h5555);
    offer(1'b1, 16'h8000);
    offer(1'b1, 16'h7FFF);
    // The first server frees on the second of these ticks, yet the queue
    // was full at its start, so that arrival is still dropped.
    offer(1'b1, 16'd3);
    offer(1'b1, 16'd3);
    offer(1'b1, 16'd5);
    offer(1'b0, 16'hFFFF);
    offer(1'b1, 16'h0000);
    offer(1'b1, 16'd1);

    sent = 0;
    while (sent < 560) begin
      burst_len   = $urandom_range(15, 60);
      arr_pct     = $urandom_range(10, 95);
      quiet_burst = ($urandom_range(3) == 0);
      case ($urandom_range(4))
        0: svc_max = 2;
        1: svc_max = 5;
        2: svc_max = 12;
        3: svc_max = 40;
        default: svc_max = 250;
      endcase
      repeat (burst_len) begin
        arrive = ($urandom_range(99) < arr_pct);
        if (!arrive) begin
          svc = IN_SVC_W'($urandom);
        end else if ($urandom_range(99) < 3) begin
          svc = '0;
        end else begin
          svc = IN_SVC_W'($urandom_range(1, svc_max));
        end
        offer(arrive, svc);
        sent++;
      end
    end

    // Let the queue drain, then start two jobs that outlast the run.
    quiet_burst = 1'b0;
    repeat (40) offer(1'b0, IN_SVC_W'($urandom));
    offer(1'b1, 16'hFFFF);
    offer(1'b1, 16'h8000);
    repeat (6) offer(1'b0, IN_SVC_W'($urandom));
    in_valid <= 1'b0;
    @(posedge clk);

    wait (waiting == 0);
    repeat (30) @(posedge clk);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/sqmsd_pkg.sv
hw/rtl/sqmsd_datapath.sv
hw/rtl/sqmsd_ctrl.sv
hw/rtl/shared_queue_multi_server_dispatch.sv
sim/dispatch_checker.sv
sim/tb_top.sv
